// ===== rtl/lpfr_pkg.sv =====
`timescale 1ns / 1ps
// types and constants for the length-prefixed frame receiver
// no dependencies

package lpfr_pkg;

	localparam logic [7:0] XOR_SEED      = 8'hFF;
	localparam logic [7:0] MIN_FRAME_LEN = 8'd3;

	typedef enum logic [1:0] {
		KIND_COMMAND  = 2'd0,
		KIND_PAYLOAD  = 2'd1,
		KIND_GOOD_END = 2'd2,
		KIND_BAD_END  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
	} result_t;

endpackage

// ===== rtl/length_prefixed_frame_receiver_unit.sv =====
`timescale 1ns / 1ps
// length-prefixed frame receiver: one byte in per item, command/payload/end items out
// a result goes into the result register behind res_*, or into the skid register while that output is stalled
// throughput: one byte per cycle while rx_stall is low; frame state and result are done in one pass
// a skid register behind the result register keeps input going for one stalled result
// reset (arst_n low, asynchronous) returns to waiting for a length byte, outputs empty
// depends on lpfr_pkg

module length_prefixed_frame_receiver_unit
	import lpfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [1:0] kind,
	output logic [7:0] value
);

	logic       in_frame_q;
	logic [7:0] frame_length_q;
	logic [7:0] bytes_seen_q;
	logic [7:0] running_xor_q;

	logic       out_valid_q;
	result_t    out_q;
	logic       skid_valid_q;
	result_t    skid_q;

	logic       accept;
	logic       pop;
	logic       body_byte;
	logic       new_res;
	result_t    new_item;

	assign rx_stall = skid_valid_q;
	assign accept   = rx_valid && !skid_valid_q;
	assign pop      = out_valid_q && !res_stall;

	// a byte before the checksum position is command or payload
	assign body_byte = ({1'b0, bytes_seen_q} + 9'd1) < {1'b0, frame_length_q};

	always_comb begin
		new_res  = 1'b0;
		new_item = '{kind: KIND_COMMAND, value: rx_byte};
		if (in_frame_q) begin
			new_res = 1'b1;
			if (body_byte) begin
				new_item.kind  = (bytes_seen_q == 8'd1) ? KIND_COMMAND : KIND_PAYLOAD;
				new_item.value = rx_byte;
			end else begin
				new_item.kind  = (running_xor_q == rx_byte) ? KIND_GOOD_END : KIND_BAD_END;
				new_item.value = frame_length_q - MIN_FRAME_LEN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q     <= 1'b0;
			frame_length_q <= '0;
			bytes_seen_q   <= '0;
			running_xor_q  <= XOR_SEED;
		end else if (accept) begin
			if (!in_frame_q) begin
				// short length bytes are dropped while idle
				if (rx_byte >= MIN_FRAME_LEN) begin
					in_frame_q     <= 1'b1;
					frame_length_q <= rx_byte;
					bytes_seen_q   <= 8'd1;
					running_xor_q  <= XOR_SEED ^ rx_byte;
				end
			end else if (body_byte) begin
				bytes_seen_q  <= bytes_seen_q + 8'd1;
				running_xor_q <= running_xor_q ^ rx_byte;
			end else begin
				in_frame_q     <= 1'b0;
				frame_length_q <= '0;
				bytes_seen_q   <= '0;
				running_xor_q  <= XOR_SEED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop || !out_valid_q) begin
			out_valid_q  <= skid_valid_q || (accept && new_res);
			skid_valid_q <= 1'b0;
		end else if (accept && new_res) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : new_item;
		end else if (accept && new_res) begin
			skid_q <= new_item;
		end
	end

	assign res_valid = out_valid_q;
	assign kind      = out_q.kind;
	assign value     = out_q.value;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid item held without a result in the output register");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && res_stall))
		else $error("skid register filled while the output was free");

	a_frame_len: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> (frame_length_q >= MIN_FRAME_LEN) && (bytes_seen_q < frame_length_q)
			&& (bytes_seen_q != 8'd0))
		else $error("frame counters out of range");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (bytes_seen_q == 8'd0) && (running_xor_q == XOR_SEED))
		else $error("idle state not cleared");

	a_end_leaves_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_frame_q && !body_byte) |=> !in_frame_q)
		else $error("frame not closed after checksum byte");

endmodule
